### rtl/bpfa_pkg.sv
// Shared types, constants and helper functions for the bitmap page-frame allocator.
// Used by bitmap_page_frame_allocator_core; depends on nothing else.

package bpfa_pkg;

    // Bitmap geometry.
    localparam int unsigned MAX_FRAMES  = 32768;
    localparam int unsigned WORD_BITS   = 32;
    localparam int unsigned WORD_SHIFT  = $clog2(WORD_BITS);
    localparam int unsigned MAP_WORDS   = MAX_FRAMES / WORD_BITS;
    localparam int unsigned WORD_AW     = $clog2(MAP_WORDS);
    localparam int unsigned FRAME_SHIFT = 12;

    // Widths fixed by the register and field definitions.
    localparam int unsigned CNT_W       = 16;
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned PADDR_W     = 4;
    localparam int unsigned PDATA_W     = 32;
    localparam int unsigned NWORD_W     = CNT_W - WORD_SHIFT;

    localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0010_0000;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NOP   = 2'd3
    } bpfa_op_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2
    } bpfa_status_t;

    typedef enum logic [1:0] {
        REG_FRAME_COUNT = 2'd0,
        REG_RESERVED    = 2'd1,
        REG_BASE        = 2'd2
    } bpfa_reg_t;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_FREE_CHK,
        ST_FREE_WR,
        ST_ALLOC_CHK,
        ST_DONE
    } bpfa_state_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] address;
    } bpfa_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] frame_address;
        logic [1:0]        status;
    } bpfa_rsp_t;

    typedef struct packed {
        logic                  hit;
        logic [WORD_SHIFT-1:0] idx;
    } bpfa_pick_t;

    // Lowest set bit of a word: isolate it with v & -v, then encode the one-hot.
    function automatic bpfa_pick_t bpfa_lowest_set(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] iso;
        bpfa_pick_t           r;
        iso   = v & (~v + WORD_BITS'(1));
        r.hit = |v;
        r.idx = '0;
        for (int k = 0; k < WORD_SHIFT; k++) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                if (i[k]) begin
                    r.idx[k] = r.idx[k] | iso[i];
                end
            end
        end
        return r;
    endfunction

endpackage

### rtl/bpfa_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Generic; holds the allocator's used-frame bitmap. No package dependencies.

module bpfa_ram #(
    parameter int unsigned AW = 10,
    parameter int unsigned DW = 32
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/bitmap_page_frame_allocator_core.sv
// Top level of the bitmap page-frame allocator (next-fit) with its APB register port.
// Depends on bpfa_pkg for types and helpers and on bpfa_ram for the bitmap storage.

// The allocator manages 4 KiB frames with one used bit per frame, kept in a
// 1024 x 32 bit synchronous RAM, plus a next-fit cursor. Each item on the s_
// channel is an allocate, free, initialize or no-op request and produces exactly
// one item on the m_ channel. The work of an item passes through these states:
// a free checks the range of its address, then clears the bit with a RAM write
// (an out-of-range address skips the write); a no-op and an allocate on an empty
// region go straight to the result; any other allocate scans the bitmap one word
// per step, reading at most one word more than the effective frame count has
// whole words; and an initialize walks all 1024 bitmap words at one RAM write
// per cycle. The result register is loaded from the done state once the previous
// result has been taken. The scan speed is set by the single RAM read port, one
// 32-bit word per cycle. After reset the block runs a clearing pass over all
// 1024 RAM words with s_ready low; register reads and writes work during that
// time. The block handles one item at a time, but it accepts the next item
// while an earlier result still sits in the output register. Registers (APB,
// byte addresses): 0x0 frame_count, 0x4 reserved_frames, 0x8 base_address; write
// them only while the block is idle.

module bitmap_page_frame_allocator_core (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  bpfa_pkg::bpfa_req_t          s_data,

    output logic                         m_valid,
    input  logic                         m_ready,
    output bpfa_pkg::bpfa_rsp_t          m_data,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpfa_pkg::PADDR_W-1:0] paddr,
    input  logic [bpfa_pkg::PDATA_W-1:0] pwdata,
    output logic [bpfa_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int unsigned AW    = bpfa_pkg::WORD_AW;
    localparam int unsigned DW    = bpfa_pkg::WORD_BITS;
    localparam int unsigned BW    = bpfa_pkg::WORD_SHIFT;
    localparam int unsigned CW    = bpfa_pkg::CNT_W;
    localparam int unsigned NW    = bpfa_pkg::NWORD_W;
    localparam int unsigned XW    = bpfa_pkg::ADDR_W;
    localparam int unsigned FS    = bpfa_pkg::FRAME_SHIFT;
    localparam int unsigned FW    = XW - FS;
    localparam int unsigned PADDR_HI = bpfa_pkg::PADDR_W - 1;
    localparam logic [CW-1:0] MaxFrames = CW'(bpfa_pkg::MAX_FRAMES);
    localparam logic [AW-1:0] LastWord  = AW'(bpfa_pkg::MAP_WORDS - 1);
    localparam logic [DW-1:0] AllOnes   = '1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CW-1:0] frame_count_reg;
    logic [CW-1:0] reserved_frames_reg;
    logic [XW-1:0] base_address_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg     <= '0;
            reserved_frames_reg <= '0;
            base_address_reg    <= bpfa_pkg::BASE_RESET;
        end else if (cfg_wr) begin
            unique case (bpfa_pkg::bpfa_reg_t'(paddr[PADDR_HI:2]))
                bpfa_pkg::REG_FRAME_COUNT: frame_count_reg     <= pwdata[CW-1:0];
                bpfa_pkg::REG_RESERVED:    reserved_frames_reg <= pwdata[CW-1:0];
                bpfa_pkg::REG_BASE:        base_address_reg    <= pwdata[XW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (bpfa_pkg::bpfa_reg_t'(paddr[PADDR_HI:2]))
            bpfa_pkg::REG_FRAME_COUNT: prdata = bpfa_pkg::PDATA_W'(frame_count_reg);
            bpfa_pkg::REG_RESERVED:    prdata = bpfa_pkg::PDATA_W'(reserved_frames_reg);
            bpfa_pkg::REG_BASE:        prdata = bpfa_pkg::PDATA_W'(base_address_reg);
            default:                   prdata = '0;
        endcase
    end

    // Effective frame count: clamped to the bitmap size, rounded down to whole words.
    logic [CW-1:0] capped_count;
    logic [CW-1:0] eff_count;
    logic [NW-1:0] n_words;

    assign capped_count = (frame_count_reg > MaxFrames) ? MaxFrames : frame_count_reg;
    assign eff_count    = {capped_count[CW-1:BW], {BW{1'b0}}};
    assign n_words      = eff_count[CW-1:BW];

    // ------------------------------------------------------------------
    // Bitmap RAM
    // ------------------------------------------------------------------
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;

    bpfa_ram #(
        .AW (AW),
        .DW (DW)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    bpfa_pkg::bpfa_state_t state_reg, state_next;

    logic [CW-1:0] cursor_reg,    cursor_next;     // next-fit cursor
    logic [CW-1:0] start_reg,     start_next;      // wrapped cursor at scan start
    logic [AW-1:0] word_reg,      word_next;       // bitmap word being scanned
    logic [BW-1:0] off_reg,       off_next;        // bit offset of the scan start
    logic [NW:0]   visits_reg,    visits_next;     // word reads left in the scan
    logic          first_reg,     first_next;
    logic [AW-1:0] wipe_idx_reg,  wipe_idx_next;
    logic [CW-1:0] wipe_lim_reg,  wipe_lim_next;   // frames to mark used
    logic          wipe_init_reg, wipe_init_next;  // wipe belongs to an initialize item
    logic [XW-1:0] diff_reg,      diff_next;       // address minus base for a free
    logic          borrow_reg,    borrow_next;     // address below base
    logic [1:0]    res_status_reg, res_status_next;
    logic          res_alloc_reg,  res_alloc_next;
    logic          m_valid_reg,    m_valid_next;
    bpfa_pkg::bpfa_rsp_t m_data_reg, m_data_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bpfa_pkg::ST_WIPE;
            cursor_reg    <= '0;
            wipe_idx_reg  <= '0;
            wipe_lim_reg  <= '0;
            wipe_init_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            wipe_idx_reg  <= wipe_idx_next;
            wipe_lim_reg  <= wipe_lim_next;
            wipe_init_reg <= wipe_init_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg      <= start_next;
        word_reg       <= word_next;
        off_reg        <= off_next;
        visits_reg     <= visits_next;
        first_reg      <= first_next;
        diff_reg       <= diff_next;
        borrow_reg     <= borrow_next;
        res_status_reg <= res_status_next;
        res_alloc_reg  <= res_alloc_next;
        m_data_reg     <= m_data_next;
    end

    // Scan helpers. The first read of a scan only looks at bits at or above the
    // start offset; when the start is mid-word, the last read revisits that word
    // and looks only at the bits below it.
    logic [CW-1:0]       start_frame;
    logic [DW-1:0]       scan_mask;
    logic                last_partial;
    bpfa_pkg::bpfa_pick_t pick;
    logic [NW-1:0]       word_inc;
    logic [AW-1:0]       word_wrap;
    logic [XW:0]         free_sub;
    logic [FW-1:0]       free_frame;
    logic [NW-1:0]       lim_words;
    logic [DW-1:0]       wipe_data;

    assign start_frame  = (cursor_reg >= eff_count) ? '0 : cursor_reg;
    assign last_partial = !first_reg && (visits_reg == (NW+1)'(1)) && (off_reg != '0);
    assign scan_mask    = first_reg    ? (AllOnes << off_reg) :
                          last_partial ? ~(AllOnes << off_reg) : AllOnes;
    assign pick         = bpfa_pkg::bpfa_lowest_set(~mem_rdata & scan_mask);
    assign word_inc     = NW'(word_reg) + NW'(1);
    assign word_wrap    = (word_inc == n_words) ? '0 : word_inc[AW-1:0];
    assign free_sub     = {1'b0, s_data.address} - {1'b0, base_address_reg};
    assign free_frame   = diff_reg[XW-1:FS];
    assign lim_words    = wipe_lim_reg[CW-1:BW];

    always_comb begin
        if (NW'(wipe_idx_reg) < lim_words) begin
            wipe_data = AllOnes;
        end else if (NW'(wipe_idx_reg) == lim_words) begin
            wipe_data = (DW'(1) << wipe_lim_reg[BW-1:0]) - DW'(1);
        end else begin
            wipe_data = '0;
        end
    end

    // ------------------------------------------------------------------
    // Next state and datapath
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        start_next      = start_reg;
        word_next       = word_reg;
        off_next        = off_reg;
        visits_next     = visits_reg;
        first_next      = first_reg;
        wipe_idx_next   = wipe_idx_reg;
        wipe_lim_next   = wipe_lim_reg;
        wipe_init_next  = wipe_init_reg;
        diff_next       = diff_reg;
        borrow_next     = borrow_reg;
        res_status_next = res_status_reg;
        res_alloc_next  = res_alloc_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = word_reg;
        mem_wdata       = mem_rdata;
        mem_raddr       = word_reg;
        s_ready         = 1'b0;

        unique case (state_reg)
            bpfa_pkg::ST_WIPE: begin
                // Clearing pass after reset, or the walk of an initialize item.
                mem_we        = 1'b1;
                mem_waddr     = wipe_idx_reg;
                mem_wdata     = wipe_data;
                wipe_idx_next = wipe_idx_reg + AW'(1);
                if (wipe_idx_reg == LastWord) begin
                    res_status_next = bpfa_pkg::STS_OK;
                    res_alloc_next  = 1'b0;
                    state_next      = wipe_init_reg ? bpfa_pkg::ST_DONE : bpfa_pkg::ST_IDLE;
                end
            end

            bpfa_pkg::ST_IDLE: begin
                s_ready         = 1'b1;
                res_status_next = bpfa_pkg::STS_OK;
                res_alloc_next  = 1'b0;
                mem_raddr       = start_frame[BW +: AW];
                if (s_valid) begin
                    unique case (bpfa_pkg::bpfa_op_t'(s_data.op))
                        bpfa_pkg::OP_ALLOC: begin
                            if (n_words == '0) begin
                                res_status_next = bpfa_pkg::STS_FULL;
                                state_next      = bpfa_pkg::ST_DONE;
                            end else begin
                                start_next  = start_frame;
                                word_next   = start_frame[BW +: AW];
                                off_next    = start_frame[BW-1:0];
                                visits_next = (NW+1)'(n_words)
                                            + (NW+1)'(start_frame[BW-1:0] != '0);
                                first_next  = 1'b1;
                                state_next  = bpfa_pkg::ST_ALLOC_CHK;
                            end
                        end
                        bpfa_pkg::OP_FREE: begin
                            diff_next   = free_sub[XW-1:0];
                            borrow_next = free_sub[XW];
                            state_next  = bpfa_pkg::ST_FREE_CHK;
                        end
                        bpfa_pkg::OP_INIT: begin
                            wipe_lim_next  = (reserved_frames_reg < eff_count)
                                           ? reserved_frames_reg : eff_count;
                            wipe_idx_next  = '0;
                            wipe_init_next = 1'b1;
                            cursor_next    = reserved_frames_reg;
                            state_next     = bpfa_pkg::ST_WIPE;
                        end
                        default: begin
                            state_next = bpfa_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            bpfa_pkg::ST_FREE_CHK: begin
                mem_raddr = diff_reg[FS+BW +: AW];
                if (borrow_reg || (free_frame >= FW'(eff_count))) begin
                    res_status_next = bpfa_pkg::STS_RANGE;
                    state_next      = bpfa_pkg::ST_DONE;
                end else begin
                    state_next = bpfa_pkg::ST_FREE_WR;
                end
            end

            bpfa_pkg::ST_FREE_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = diff_reg[FS+BW +: AW];
                mem_wdata  = mem_rdata & ~(DW'(1) << diff_reg[FS +: BW]);
                state_next = bpfa_pkg::ST_DONE;
            end

            bpfa_pkg::ST_ALLOC_CHK: begin
                mem_raddr = word_wrap;
                if (pick.hit) begin
                    mem_we         = 1'b1;
                    mem_waddr      = word_reg;
                    mem_wdata      = mem_rdata | (DW'(1) << pick.idx);
                    cursor_next    = CW'({word_reg, pick.idx});
                    res_alloc_next = 1'b1;
                    state_next     = bpfa_pkg::ST_DONE;
                end else if (visits_reg == (NW+1)'(1)) begin
                    // Every frame tested once; the cursor ends where the scan left it.
                    cursor_next     = (start_reg == '0) ? eff_count : start_reg;
                    res_status_next = bpfa_pkg::STS_FULL;
                    state_next      = bpfa_pkg::ST_DONE;
                end else begin
                    visits_next = visits_reg - (NW+1)'(1);
                    first_next  = 1'b0;
                    word_next   = word_wrap;
                end
            end

            bpfa_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.status        = res_status_reg;
                    m_data_next.frame_address = res_alloc_reg
                        ? base_address_reg + {(FW-CW)'(0), cursor_reg, {FS{1'b0}}}
                        : '0;
                    state_next                = bpfa_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = bpfa_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while the previous one is still being worked");

    a_no_intake_during_wipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bpfa_pkg::ST_WIPE) |-> !s_ready)
        else $error("input ready during a bitmap wipe");

    a_failed_result_has_no_address: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != bpfa_pkg::STS_OK)) |-> (m_data.frame_address == '0))
        else $error("failed result carries a frame address");

    a_scan_has_budget: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bpfa_pkg::ST_ALLOC_CHK) |-> (visits_reg != '0))
        else $error("allocation scan ran past its word budget");

    a_write_only_when_working: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == bpfa_pkg::ST_WIPE || state_reg == bpfa_pkg::ST_FREE_WR
                    || state_reg == bpfa_pkg::ST_ALLOC_CHK))
        else $error("bitmap written outside a write state");

endmodule
